/* hdl/cpsn_pkg.sv */
// ----------------------------------------------------------------------------
// cpsn_pkg
// Widths, reset values and register codes of the cross-power normalizer.
// ----------------------------------------------------------------------------
package cpsn_pkg;

   // beat fields
   localparam int IN_W   = 24;   // Q16.8 spectrum parts
   localparam int OUT_W  = 16;   // Q1.15 normalized parts
   localparam int EPS_W  = 16;   // epsilon, Q.16

   // datapath widths
   localparam int HALF_W = 24;          // half of a magnitude for squaring
   localparam int PROD_W = 2 * IN_W;    // Q32.16 partial product
   localparam int X_W    = PROD_W + 1;  // cross-power part
   localparam int MAG_W  = PROD_W;      // |X_re|, |X_im| and sqrt result
   localparam int SQ_W   = 2 * MAG_W;   // squared magnitude
   localparam int DEN_W  = MAG_W + 1;   // magnitude plus epsilon
   localparam int FRAC_W = 15;          // output fraction bits
   localparam int NUM_W  = 64;          // (|X| << 15) + den/2
   localparam int Q_W    = FRAC_W + 1;  // quotient, up to 1.0

   // configuration port
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

   // register word index codes
   localparam logic [CSR_AW-3:0] REG_EPS_OFFSET = 1'b0;

endpackage

/* hdl/cpsn_if.sv */
// ----------------------------------------------------------------------------
// cpsn_req_if / cpsn_rsp_if
// Valid/ready stream channels for spectrum bin pairs and normalized bins.
// ----------------------------------------------------------------------------
interface cpsn_req_if;
   import cpsn_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [IN_W-1:0]  prev_re;
   logic signed [IN_W-1:0]  prev_im;
   logic signed [IN_W-1:0]  cur_re;
   logic signed [IN_W-1:0]  cur_im;

   modport source (output valid, output prev_re, output prev_im,
                   output cur_re, output cur_im, input ready);
   modport sink   (input valid, input prev_re, input prev_im,
                   input cur_re, input cur_im, output ready);
endinterface

interface cpsn_rsp_if;
   import cpsn_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] norm_re;
   logic signed [OUT_W-1:0] norm_im;

   modport source (output valid, output norm_re, output norm_im, input ready);
   modport sink   (input valid, input norm_re, input norm_im, output ready);
endinterface

/* hdl/cross_power_spectrum_normalize.sv */
// ----------------------------------------------------------------------------
// cross_power_spectrum_normalize
// Throughput: one beat per cycle unless a result waits at the output, set by
//   the 48 sqrt and 16 divide stages each retiring one result bit per stage.
// Reset: synchronous, active high; clears all valid bits and the skid slot,
//   eps_offset returns to 66. No clearing pass.
// ----------------------------------------------------------------------------
module cross_power_spectrum_normalize (
   input  logic                          clock,
   input  logic                          reset,
   cpsn_req_if.sink                      req_if,
   cpsn_rsp_if.source                    rsp_if,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cpsn_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [cpsn_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [cpsn_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import cpsn_pkg::*;

   // -------------------------------------------------------------------------
   // Local stage types
   // -------------------------------------------------------------------------
   typedef struct packed {
      logic signed [IN_W-1:0] pr;
      logic signed [IN_W-1:0] pi;
      logic signed [IN_W-1:0] cr;
      logic signed [IN_W-1:0] ci;
   } in_beat_type;

   // one restoring sqrt step: rem = N - root^2
   typedef struct packed {
      logic [SQ_W-1:0]  rem;
      logic [MAG_W-1:0] root;
      logic [MAG_W-1:0] ar;
      logic [MAG_W-1:0] ai;
      logic             neg_r;
      logic             neg_i;
   } sqrt_type;

   // one restoring divide step for both parts sharing a divisor
   typedef struct packed {
      logic [NUM_W-1:0] rem_r;
      logic [NUM_W-1:0] rem_i;
      logic [DEN_W-1:0] den;
      logic [Q_W-1:0]   q_r;
      logic [Q_W-1:0]   q_i;
      logic             neg_r;
      logic             neg_i;
      logic             dz;
   } div_type;

   // sign and saturate a Q1.15 quotient
   function automatic logic [OUT_W-1:0] sign_sat(input logic [Q_W-1:0] q,
                                                 input logic neg,
                                                 input logic dz);
      logic [OUT_W-1:0] r;
      if (dz) begin
         r = '0;
      end else if (neg) begin
         r = OUT_W'(~q + Q_W'(1));
      end else if (q[Q_W-1]) begin
         r = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
         r = OUT_W'(q);
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Configuration: eps_offset only; word decode ignores byte lanes
   // -------------------------------------------------------------------------
   logic [EPS_W-1:0] eps_ff;
   logic             csr_hit;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_AW-1:2] == REG_EPS_OFFSET);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? {{(CSR_DW-EPS_W){1'b0}}, eps_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_wr) begin
         eps_ff <= csr_pwdata[EPS_W-1:0];
      end
   end

   // -------------------------------------------------------------------------
   // Flow control
   // The whole pipe moves on adv. A result waiting at the output stops it;
   // the skid slot in front still takes one more req beat, so req_ready
   // never depends on rsp_ready in the same cycle.
   // -------------------------------------------------------------------------
   logic        out_v_ff;
   logic        adv;
   logic        acc;
   logic        skid_full_ff;
   in_beat_type skid_ff;
   in_beat_type req_beat;
   in_beat_type in_beat;
   logic        in_v;

   assign adv           = !out_v_ff || rsp_if.ready;
   assign req_if.ready  = !skid_full_ff;
   assign acc           = req_if.valid && !skid_full_ff;

   always_comb begin
      req_beat.pr = req_if.prev_re;
      req_beat.pi = req_if.prev_im;
      req_beat.cr = req_if.cur_re;
      req_beat.ci = req_if.cur_im;
   end

   assign in_beat = skid_full_ff ? skid_ff : req_beat;
   assign in_v    = skid_full_ff || acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (adv) begin
         skid_full_ff <= 1'b0;        // skid drains into stage 1
      end else if (acc) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && acc) begin
         skid_ff <= req_beat;
      end
   end

   // -------------------------------------------------------------------------
   // Stages 1..5: cross-power, magnitude parts, squared magnitude
   // -------------------------------------------------------------------------
   logic                     s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic signed [PROD_W-1:0] s1_rr_ff, s1_ii_ff, s1_ir_ff, s1_ri_ff;
   logic signed [X_W-1:0]    s2_xr_ff, s2_xi_ff;
   logic [MAG_W-1:0]         s3_ar_ff, s3_ai_ff;
   logic                     s3_neg_r_ff, s3_neg_i_ff;
   logic [PROD_W-1:0]        s4_hh_r_ff, s4_hl_r_ff, s4_ll_r_ff;
   logic [PROD_W-1:0]        s4_hh_i_ff, s4_hl_i_ff, s4_ll_i_ff;
   logic [MAG_W-1:0]         s4_ar_ff, s4_ai_ff;
   logic                     s4_neg_r_ff, s4_neg_i_ff;
   logic [SQ_W-1:0]          s5_sq_r_ff, s5_sq_i_ff;
   logic [MAG_W-1:0]         s5_ar_ff, s5_ai_ff;
   logic                     s5_neg_r_ff, s5_neg_i_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: four 24x24 signed products, P * conj(C)
         s1_rr_ff <= $signed(in_beat.pr) * $signed(in_beat.cr);
         s1_ii_ff <= $signed(in_beat.pi) * $signed(in_beat.ci);
         s1_ir_ff <= $signed(in_beat.pi) * $signed(in_beat.cr);
         s1_ri_ff <= $signed(in_beat.pr) * $signed(in_beat.ci);
         // stage 2: X_re, X_im (one bit of growth)
         s2_xr_ff <= X_W'(s1_rr_ff) + X_W'(s1_ii_ff);
         s2_xi_ff <= X_W'(s1_ir_ff) - X_W'(s1_ri_ff);
         // stage 3: sign and magnitude, |X| <= 2^47 fits 48 bits
         s3_neg_r_ff <= s2_xr_ff[X_W-1];
         s3_neg_i_ff <= s2_xi_ff[X_W-1];
         s3_ar_ff    <= s2_xr_ff[X_W-1] ? MAG_W'(-s2_xr_ff) : MAG_W'(s2_xr_ff);
         s3_ai_ff    <= s2_xi_ff[X_W-1] ? MAG_W'(-s2_xi_ff) : MAG_W'(s2_xi_ff);
         // stage 4: 48-bit squares split into 24x24 partial products
         s4_hh_r_ff  <= s3_ar_ff[MAG_W-1:HALF_W] * s3_ar_ff[MAG_W-1:HALF_W];
         s4_hl_r_ff  <= s3_ar_ff[MAG_W-1:HALF_W] * s3_ar_ff[HALF_W-1:0];
         s4_ll_r_ff  <= s3_ar_ff[HALF_W-1:0] * s3_ar_ff[HALF_W-1:0];
         s4_hh_i_ff  <= s3_ai_ff[MAG_W-1:HALF_W] * s3_ai_ff[MAG_W-1:HALF_W];
         s4_hl_i_ff  <= s3_ai_ff[MAG_W-1:HALF_W] * s3_ai_ff[HALF_W-1:0];
         s4_ll_i_ff  <= s3_ai_ff[HALF_W-1:0] * s3_ai_ff[HALF_W-1:0];
         s4_ar_ff    <= s3_ar_ff;
         s4_ai_ff    <= s3_ai_ff;
         s4_neg_r_ff <= s3_neg_r_ff;
         s4_neg_i_ff <= s3_neg_i_ff;
         // stage 5: hi^2 * 2^48 + 2*hi*lo * 2^24 + lo^2
         s5_sq_r_ff  <= {s4_hh_r_ff, {MAG_W{1'b0}}}
                        + (SQ_W'(s4_hl_r_ff) << (HALF_W + 1)) + SQ_W'(s4_ll_r_ff);
         s5_sq_i_ff  <= {s4_hh_i_ff, {MAG_W{1'b0}}}
                        + (SQ_W'(s4_hl_i_ff) << (HALF_W + 1)) + SQ_W'(s4_ll_i_ff);
         s5_ar_ff    <= s4_ar_ff;
         s5_ai_ff    <= s4_ai_ff;
         s5_neg_r_ff <= s4_neg_r_ff;
         s5_neg_i_ff <= s4_neg_i_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Square root: stage 6 loads N = |X_re|^2 + |X_im|^2, then 48 stages
   // each decide one root bit, MSB first, by the restoring test
   //   rem >= (root << (b+1)) | (1 << 2b)
   // -------------------------------------------------------------------------
   sqrt_type sq_ff [0:MAG_W];
   sqrt_type sq_in [0:MAG_W];
   logic     sq_v_ff [0:MAG_W];

   always_comb begin
      sq_in[0].rem   = s5_sq_r_ff + s5_sq_i_ff;   // < 2^96, no carry out
      sq_in[0].root  = '0;
      sq_in[0].ar    = s5_ar_ff;
      sq_in[0].ai    = s5_ai_ff;
      sq_in[0].neg_r = s5_neg_r_ff;
      sq_in[0].neg_i = s5_neg_i_ff;
   end

   for (genvar k = 0; k < MAG_W; k++) begin : g_sqrt
      localparam int B = MAG_W - 1 - k;
      logic [SQ_W-1:0] sub;
      logic [SQ_W:0]   diff;

      always_comb begin
         sub  = (SQ_W'(sq_ff[k].root) << (B + 1)) | (SQ_W'(1) << (2 * B));
         diff = {1'b0, sq_ff[k].rem} - {1'b0, sub};
         sq_in[k+1] = sq_ff[k];
         if (!diff[SQ_W]) begin
            sq_in[k+1].rem  = diff[SQ_W-1:0];
            sq_in[k+1].root = sq_ff[k].root | (MAG_W'(1) << B);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= MAG_W; i++) begin
            sq_ff[i] <= sq_in[i];
         end
      end
   end

   // -------------------------------------------------------------------------
   // Divisor: D = M + eps, then the rounded numerators (|X| << 15) + D/2
   // -------------------------------------------------------------------------
   logic             dn_v_ff;
   logic [DEN_W-1:0] dn_den_ff;
   logic [MAG_W-1:0] dn_ar_ff, dn_ai_ff;
   logic             dn_neg_r_ff, dn_neg_i_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dn_den_ff   <= DEN_W'(sq_ff[MAG_W].root) + DEN_W'(eps_ff);
         dn_ar_ff    <= sq_ff[MAG_W].ar;
         dn_ai_ff    <= sq_ff[MAG_W].ai;
         dn_neg_r_ff <= sq_ff[MAG_W].neg_r;
         dn_neg_i_ff <= sq_ff[MAG_W].neg_i;
      end
   end

   // -------------------------------------------------------------------------
   // Divide: |X| <= M <= D, so the quotient is at most 2^15 and 16 restoring
   // stages cover it, MSB first. D = 0 only with X = 0; flagged, result 0.
   // -------------------------------------------------------------------------
   div_type dv_ff [0:Q_W];
   div_type dv_in [0:Q_W];
   logic    dv_v_ff [0:Q_W];

   always_comb begin
      dv_in[0].rem_r = (NUM_W'(dn_ar_ff) << FRAC_W) + NUM_W'(dn_den_ff >> 1);
      dv_in[0].rem_i = (NUM_W'(dn_ai_ff) << FRAC_W) + NUM_W'(dn_den_ff >> 1);
      dv_in[0].den   = dn_den_ff;
      dv_in[0].q_r   = '0;
      dv_in[0].q_i   = '0;
      dv_in[0].neg_r = dn_neg_r_ff;
      dv_in[0].neg_i = dn_neg_i_ff;
      dv_in[0].dz    = (dn_den_ff == '0);
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      localparam int K = Q_W - 1 - j;
      logic [NUM_W-1:0] sub;
      logic [NUM_W:0]   diff_r;
      logic [NUM_W:0]   diff_i;

      always_comb begin
         sub    = NUM_W'(dv_ff[j].den) << K;
         diff_r = {1'b0, dv_ff[j].rem_r} - {1'b0, sub};
         diff_i = {1'b0, dv_ff[j].rem_i} - {1'b0, sub};
         dv_in[j+1] = dv_ff[j];
         if (!diff_r[NUM_W]) begin
            dv_in[j+1].rem_r = diff_r[NUM_W-1:0];
            dv_in[j+1].q_r   = dv_ff[j].q_r | (Q_W'(1) << K);
         end
         if (!diff_i[NUM_W]) begin
            dv_in[j+1].rem_i = diff_i[NUM_W-1:0];
            dv_in[j+1].q_i   = dv_ff[j].q_i | (Q_W'(1) << K);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= Q_W; i++) begin
            dv_ff[i] <= dv_in[i];
         end
      end
   end

   // -------------------------------------------------------------------------
   // Output register: sign, saturate +1.0 to 32767
   // -------------------------------------------------------------------------
   logic [OUT_W-1:0] out_re_ff, out_im_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_re_ff <= sign_sat(dv_ff[Q_W].q_r, dv_ff[Q_W].neg_r, dv_ff[Q_W].dz);
         out_im_ff <= sign_sat(dv_ff[Q_W].q_i, dv_ff[Q_W].neg_i, dv_ff[Q_W].dz);
      end
   end

   assign rsp_if.valid   = out_v_ff;
   assign rsp_if.norm_re = out_re_ff;
   assign rsp_if.norm_im = out_im_ff;

   // -------------------------------------------------------------------------
   // Valid bits travel with the data
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         for (int i = 0; i <= MAG_W; i++) begin
            sq_v_ff[i] <= 1'b0;
         end
         dn_v_ff  <= 1'b0;
         for (int i = 0; i <= Q_W; i++) begin
            dv_v_ff[i] <= 1'b0;
         end
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff    <= in_v;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         s4_v_ff    <= s3_v_ff;
         s5_v_ff    <= s4_v_ff;
         sq_v_ff[0] <= s5_v_ff;
         for (int i = 1; i <= MAG_W; i++) begin
            sq_v_ff[i] <= sq_v_ff[i-1];
         end
         dn_v_ff    <= sq_v_ff[MAG_W];
         dv_v_ff[0] <= dn_v_ff;
         for (int i = 1; i <= Q_W; i++) begin
            dv_v_ff[i] <= dv_v_ff[i-1];
         end
         out_v_ff   <= dv_v_ff[Q_W];
      end
   end

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // finished root leaves a remainder no larger than 2*root
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      sq_v_ff[MAG_W] |-> (sq_ff[MAG_W].rem <= (SQ_W'(sq_ff[MAG_W].root) << 1)))
      else $error("sqrt remainder out of range");

   // quotient never exceeds 1.0
   a_quot_max: assert property (@(posedge clock) disable iff (reset)
      (dv_v_ff[Q_W] && !dv_ff[Q_W].dz) |->
         (dv_ff[Q_W].q_r <= (Q_W'(1) << FRAC_W)) && (dv_ff[Q_W].q_i <= (Q_W'(1) << FRAC_W)))
      else $error("quotient above 1.0");

   // a held skid beat leaves on the next advance
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_full_ff && adv) |=> !skid_full_ff)
      else $error("skid slot not drained");
`endif

endmodule

/* sim/cross_power_spectrum_normalize_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_power_spectrum_normalize_tb
// Self-checking bench for the per-bin cross-power normalizer. Bin pairs are
// streamed in with random gaps, each accepted beat is run through a bit-exact
// model of conj-multiply, integer sqrt, epsilon add and Q1.15 rounding
// division, and every result beat is compared in order against it. The eps
// register is swept through its extremes over the APB port between phases.
// ----------------------------------------------------------------------------
module cross_power_spectrum_normalize_tb;
   import cpsn_pkg::*;

   // one input beat: previous-frame bin and current-frame bin, Q16.8
   typedef struct packed {
      logic signed [IN_W-1:0] prev_re;
      logic signed [IN_W-1:0] prev_im;
      logic signed [IN_W-1:0] cur_re;
      logic signed [IN_W-1:0] cur_im;
   } bin_pair_type;

   // one result beat: normalized cross-power, Q1.15
   typedef struct packed {
      logic signed [OUT_W-1:0] norm_re;
      logic signed [OUT_W-1:0] norm_im;
   } norm_bin_type;

   // flavors of random field content
   typedef enum int {
      PART_FULL,      // anywhere in the 24-bit range
      PART_SMALL,     // near zero, so eps dominates the divisor
      PART_SCALED,    // full range shifted down, spans the dynamic range
      PART_CORNER     // range ends, zero and +-1
   } part_kind_type;

   localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W-1){1'b1}}};
   localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W-1){1'b0}}};
   localparam logic [CSR_AW-1:0] ADDR_EPS    = {REG_EPS_OFFSET, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_UNUSED = {~REG_EPS_OFFSET, 2'b00};
   localparam int PIPE_LATENCY = 73;
   localparam int IDLE_MAX     = 19;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   cpsn_req_if req_bus ();
   cpsn_rsp_if rsp_bus ();

   cross_power_spectrum_normalize uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench-side copy of the eps register
   logic [EPS_W-1:0] eps_shadow;

   // predicted results, oldest first, plus the bins that caused them
   norm_bin_type expected_norms[$];
   bin_pair_type pending_bins[$];

   int error_count;
   int bins_sent;
   int norms_checked;
   int eps_writes;
   bit reset_done;

   // per-side idle ceilings; zero gives back-to-back stretches
   int req_idle_max;
   int rsp_idle_max;

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // -------------------------------------------------------------------------
   // Bit-exact predictor
   // -------------------------------------------------------------------------

   // |num| * 2^15 / den, rounded half away from zero, clamped to +-1.0, and
   // +1.0 pinned to the largest positive code. A zero divisor gives zero.
   function automatic logic signed [OUT_W-1:0] scale_q15(longint num,
                                                         logic [63:0] den);
      logic [63:0] num_abs;
      logic [63:0] quo;
      longint signed_quo;
      if (den == 64'd0)
         return '0;
      num_abs = (num < 0) ? 64'(-num) : 64'(num);
      quo = ((num_abs << FRAC_W) + (den >> 1)) / den;
      if (quo > 64'd32768)
         quo = 64'd32768;
      signed_quo = (num < 0) ? -longint'(quo) : longint'(quo);
      if (signed_quo > 32767)
         signed_quo = 32767;
      return signed_quo[OUT_W-1:0];
   endfunction

   // X = P * conj(C); M = floor(sqrt(|X|^2)); result = X / (M + eps)
   function automatic norm_bin_type predict_norm(bin_pair_type bin,
                                                 logic [EPS_W-1:0] eps);
      longint pr;
      longint pi;
      longint cr;
      longint ci;
      longint xr;
      longint xi;
      logic [127:0] re_abs;
      logic [127:0] im_abs;
      logic [127:0] power;
      logic [127:0] trial;
      logic [63:0] root;
      logic [63:0] den;
      norm_bin_type res;
      pr = longint'(bin.prev_re);
      pi = longint'(bin.prev_im);
      cr = longint'(bin.cur_re);
      ci = longint'(bin.cur_im);
      xr = pr * cr + pi * ci;
      xi = pi * cr - pr * ci;
      re_abs = (xr < 0) ? 128'(-xr) : 128'(xr);
      im_abs = (xi < 0) ? 128'(-xi) : 128'(xi);
      power = re_abs * re_abs + im_abs * im_abs;
      // bitwise root, 48 result bits
      root = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = 128'(root | (64'd1 << b));
         if (trial * trial <= power)
            root = trial[63:0];
      end
      den = root + 64'(eps);
      res.norm_re = scale_q15(xr, den);
      res.norm_im = scale_q15(xi, den);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // APB register access, setup then access phase, driven on falling edges
   // -------------------------------------------------------------------------

   task automatic csr_write(input logic [CSR_AW-1:0] addr,
                            input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // only index 0 exists; upper data bits are dropped
      if (addr[CSR_AW-1:2] == REG_EPS_OFFSET)
         eps_shadow = data[EPS_W-1:0];
      eps_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check_eps();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_EPS;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[EPS_W-1:0] !== eps_shadow) begin
         $error("eps_offset readback: expected %0d, got %0d",
                eps_shadow, csr_prdata[EPS_W-1:0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Request side: one beat per call, random lead-in gap
   // -------------------------------------------------------------------------

   task automatic send_bin(input bin_pair_type bin);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      // returns right after an accepting edge, so valid is still high here
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.prev_re <= bin.prev_re;
      req_bus.prev_im <= bin.prev_im;
      req_bus.cur_re  <= bin.cur_re;
      req_bus.cur_im  <= bin.cur_im;
      do @(posedge clock); while (!req_bus.ready);
      expected_norms.push_back(predict_norm(bin, eps_shadow));
      pending_bins.push_back(bin);
      bins_sent++;
   endtask

   // drop valid and wait until every predicted beat has come back
   task automatic drain_pipeline();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (expected_norms.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // eps is only changed with the pipeline empty
   task automatic set_eps(input logic [EPS_W-1:0] eps);
      drain_pipeline();
      csr_write(ADDR_EPS, {{(CSR_DW-EPS_W){1'b0}}, eps});
   endtask

   // -------------------------------------------------------------------------
   // Response side: random stall before each beat, in-order compare
   // -------------------------------------------------------------------------

   initial begin
      int stall;
      norm_bin_type want;
      bin_pair_type cause;
      rsp_bus.ready = 1'b0;
      wait (reset_done);
      forever begin
         stall = $urandom_range(0, rsp_idle_max);
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (expected_norms.size() == 0) begin
            $error("result beat with nothing expected: norm_re %0d norm_im %0d",
                   rsp_bus.norm_re, rsp_bus.norm_im);
            error_count++;
         end else begin
            want  = expected_norms.pop_front();
            cause = pending_bins.pop_front();
            norms_checked++;
            if (rsp_bus.norm_re !== want.norm_re) begin
               $error("norm_re: expected %0d, got %0d (prev %0d,%0d cur %0d,%0d)",
                      want.norm_re, rsp_bus.norm_re, cause.prev_re,
                      cause.prev_im, cause.cur_re, cause.cur_im);
               error_count++;
            end
            if (rsp_bus.norm_im !== want.norm_im) begin
               $error("norm_im: expected %0d, got %0d (prev %0d,%0d cur %0d,%0d)",
                      want.norm_im, rsp_bus.norm_im, cause.prev_re,
                      cause.prev_im, cause.cur_re, cause.cur_im);
               error_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic bin_pair_type make_bin(logic signed [IN_W-1:0] pr,
                                             logic signed [IN_W-1:0] pi,
                                             logic signed [IN_W-1:0] cr,
                                             logic signed [IN_W-1:0] ci);
      bin_pair_type b;
      b.prev_re = pr;
      b.prev_im = pi;
      b.cur_re  = cr;
      b.cur_im  = ci;
      return b;
   endfunction

   function automatic logic signed [IN_W-1:0] rand_part(part_kind_type kind);
      logic signed [IN_W-1:0] v;
      v = IN_W'($urandom());
      case (kind)
         PART_SMALL: begin
            v = IN_W'($signed($urandom_range(0, 1023)) - 512);
         end
         PART_SCALED: begin
            v = v >>> $urandom_range(0, IN_W - 1);
         end
         PART_CORNER: begin
            case ($urandom_range(0, 4))
               0: v = IN_MAX;
               1: v = IN_MIN;
               2: v = '0;
               3: v = 1;
               default: v = -1;
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   // mostly independent parts; some bins collinear with their partner so the
   // result lands on +-1.0 or a pure axis
   function automatic bin_pair_type rand_bin();
      bin_pair_type b;
      part_kind_type kind;
      kind = part_kind_type'($urandom_range(0, 3));
      b = make_bin(rand_part(kind), rand_part(kind),
                   rand_part(kind), rand_part(kind));
      case ($urandom_range(0, 9))
         0: begin
            b.prev_re = b.cur_re;          // X real and positive
            b.prev_im = b.cur_im;
         end
         1: begin
            b.prev_re = -b.cur_re;         // X real and negative
            b.prev_im = -b.cur_im;
         end
         2: begin
            b.prev_re = -b.cur_im;         // X on the imaginary axis
            b.prev_im = b.cur_re;
         end
         default: ;
      endcase
      return b;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // eps comes out of reset at its default and is used as such
   task automatic test_reset_eps();
      csr_check_eps();
      send_bin(make_bin(0, 0, 0, 0));
      send_bin(make_bin(1, 0, 1, 0));            // eps swamps a tiny X
      send_bin(make_bin(256, -256, 512, 128));
   endtask

   // unmapped index is ignored, wide writes keep the low half only
   task automatic test_csr_access();
      drain_pipeline();
      csr_write(ADDR_UNUSED, '1);
      csr_check_eps();
      csr_write(ADDR_EPS, 32'hA5A5_5AAA);
      csr_check_eps();
      csr_write(ADDR_EPS, 32'h0000_A555);
      csr_check_eps();
      send_bin(make_bin(300, 40, -7, 1000));
   endtask

   // M and eps both zero: the zero divisor is flagged and zero is returned
   task automatic test_zero_divisor();
      set_eps('0);
      csr_check_eps();
      send_bin(make_bin(0, 0, 0, 0));
      send_bin(make_bin(IN_MAX, IN_MIN, 0, 0));
      send_bin(make_bin(0, 0, IN_MIN, IN_MAX));
   endtask

   // with no eps a collinear pair is exactly +-1.0; +1.0 pins to max code
   task automatic test_unit_saturation();
      send_bin(make_bin(IN_MAX, IN_MAX, IN_MAX, IN_MAX));
      send_bin(make_bin(IN_MIN, IN_MIN, IN_MIN, IN_MIN));
      send_bin(make_bin(IN_MIN, 0, IN_MAX, 0));
      send_bin(make_bin(0, 1000, 1000, 0));
      send_bin(make_bin(0, -1, 1, 0));
      send_bin(make_bin(1, 0, 1, 0));
   endtask

   // field extremes against the largest eps
   task automatic test_field_extremes();
      set_eps('1);
      csr_check_eps();
      send_bin(make_bin(IN_MAX, IN_MIN, IN_MIN, IN_MAX));
      send_bin(make_bin(IN_MIN, IN_MAX, IN_MAX, IN_MIN));
      send_bin(make_bin(IN_MAX, 0, 0, IN_MAX));
      send_bin(make_bin(-1, -1, -1, 1));
      send_bin(make_bin(255, 255, 255, 255));
      send_bin(make_bin(IN_MIN, IN_MIN, IN_MAX, IN_MAX));
   endtask

   // random bins over a sweep of eps values, idle patterns changed per chunk
   task automatic test_random_bins();
      logic [EPS_W-1:0] eps_sweep[6];
      eps_sweep[0] = '0;
      eps_sweep[1] = '1;
      eps_sweep[2] = EPS_RESET;
      eps_sweep[3] = 16'h5555;
      eps_sweep[4] = EPS_W'($urandom());
      eps_sweep[5] = EPS_W'($urandom_range(0, 255));
      foreach (eps_sweep[s]) begin
         set_eps(eps_sweep[s]);
         for (int chunk = 0; chunk < 3; chunk++) begin
            // both idle, neither, or only one side
            case ($urandom_range(0, 3))
               0: begin req_idle_max = IDLE_MAX; rsp_idle_max = IDLE_MAX; end
               1: begin req_idle_max = 0;        rsp_idle_max = 0;        end
               2: begin req_idle_max = IDLE_MAX; rsp_idle_max = 0;        end
               default: begin req_idle_max = 0;  rsp_idle_max = IDLE_MAX; end
            endcase
            repeat (25) send_bin(rand_bin());
         end
      end
      req_idle_max = IDLE_MAX;
      rsp_idle_max = IDLE_MAX;
   endtask

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      reset_done      = 1'b0;
      req_bus.valid   = 1'b0;
      req_bus.prev_re = '0;
      req_bus.prev_im = '0;
      req_bus.cur_re  = '0;
      req_bus.cur_im  = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      eps_shadow      = EPS_RESET;
      error_count     = 0;
      bins_sent       = 0;
      norms_checked   = 0;
      eps_writes      = 0;
      req_idle_max    = IDLE_MAX;
      rsp_idle_max    = IDLE_MAX;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset      <= 1'b0;
      reset_done = 1'b1;

      test_reset_eps();
      test_csr_access();
      test_zero_divisor();
      test_unit_saturation();
      test_field_extremes();
      test_random_bins();

      // everything back, then a latency's worth of quiet for strays
      drain_pipeline();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (expected_norms.size() != 0) begin
         $error("%0d result beats never arrived", expected_norms.size());
         error_count++;
      end

      $display("Covered %0d bin pairs and %0d checked result beats", bins_sent,
               norms_checked);
      $display("over %0d register writes, eps swept 0 to 65535.", eps_writes);
      if (error_count == 0)
         $display("[cross_power_spectrum_normalize] OK");
      else
         $display("[cross_power_spectrum_normalize] ERROR");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("[cross_power_spectrum_normalize] ERROR");
      $finish;
   end

endmodule
